>>> rtl/core/table_element_dequantizer_assert.svh
// Assertion macros shared by the dequantizer checker.
`ifndef TABLE_ELEMENT_DEQUANTIZER_ASSERT_SVH
`define TABLE_ELEMENT_DEQUANTIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TED_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ted check failed");
// Next-cycle implication outside reset.
`define TED_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ted check failed");
`endif

>>> rtl/core/ted_pkg.sv
// Package: formats, float constants and the shared stage payload type.
`default_nettype none
package ted_pkg;
    localparam logic [2:0] FMT_FP32 = 3'd0;
    localparam logic [2:0] FMT_FP16 = 3'd1;
    localparam logic [2:0] FMT_BF16 = 3'd2;
    localparam logic [2:0] FMT_INT8 = 3'd3;
    localparam logic [2:0] FMT_INT4 = 3'd4;
    localparam logic [2:0] CFG_FORMAT = 3'd0;
    localparam logic [2:0] CFG_GSCALE = 3'd1;
    localparam logic [2:0] FORMAT_RESET = FMT_BF16;
    localparam logic [31:0] GSCALE_RESET = 32'h4180_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Operands of one multiply, as they travel down the pipe.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        zero_out;
        logic        last;
    } t_mul_req;

    // Exact binary32 value of a small signed integer (-128..127).
    function automatic logic [31:0] int_to_f32(input logic signed [7:0] v);
        logic [7:0] mag;
        logic [7:0] e;
        logic [22:0] m;
        logic [31:0] r;
        mag = v[7] ? 8'(-v) : 8'(v);
        r = '0;
        e = '0;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) begin
                e = 8'(127 + i);
                m = 23'({mag, 15'd0} << (8 - i));
            end
        end
        if (mag != 8'd0) r = {v[7], e, m};
        return r;
    endfunction

    // fp16 to binary32, subnormals normalized.
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [10:0] mm;
        logic [7:0] sh;
        logic [31:0] r;
        ex = h[14:10];
        man = h[9:0];
        mm = {1'b0, man};
        sh = '0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                sh = 8'(10 - i);
                mm = 11'({1'b0, man} << (10 - i));
            end
        end
        if (ex == 5'd0) begin
            if (man == 10'd0) r = {h[15], 31'd0};
            else r = {h[15], 8'(8'd113 - sh), mm[9:0], 13'd0};
        end else if (ex == 5'h1f) begin
            r = {h[15], 8'hFF, man, 13'd0};
        end else begin
            r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/ted_front.sv
// Front stage: decode the element into multiply operands, split int4 pairs.
`default_nettype none
module ted_front
    import ted_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_format,
    input  wire logic [31:0] i_gscale,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_raw,
    input  wire logic [31:0] i_cs0,
    input  wire logic [31:0] i_cs1,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_mul_req         o_req
);
    logic r_second;
    logic [31:0] r_cs1;
    logic [3:0] r_hi;
    logic n_second;
    t_mul_req n_req;
    logic emit;

    assign o_valid = i_valid || r_second;
    assign o_ready = i_ready && !r_second;
    assign emit = o_valid && i_ready;

    always_comb begin
        n_req = '{a: '0, b: i_gscale, zero_out: 1'b0, last: 1'b1};
        if (r_second) begin
            n_req.a = int_to_f32({{4{r_hi[3]}}, r_hi});
            n_req.b = r_cs1;
        end else begin
            case (i_format)
                FMT_FP32: n_req.a = i_raw;
                FMT_FP16: n_req.a = half_to_f32(i_raw[15:0]);
                FMT_BF16: n_req.a = {i_raw[15:0], 16'd0};
                FMT_INT8: begin
                    n_req.a = int_to_f32(i_raw[7:0]);
                    n_req.b = i_cs0;
                end
                FMT_INT4: begin
                    n_req.a = int_to_f32({{4{i_raw[3]}}, i_raw[3:0]});
                    n_req.b = i_cs0;
                    n_req.last = 1'b0;
                end
                default: n_req.zero_out = 1'b1;
            endcase
        end
    end
    assign o_req = n_req;

    assign n_second = r_second ? !emit : (emit && i_format == FMT_INT4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_second <= 1'b0;
        else r_second <= n_second;
        if (!r_second && emit) begin
            r_cs1 <= i_cs1;
            r_hi <= i_raw[7:4];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ted_fmul.sv
// Three-stage binary32 multiplier, RNE, subnormals kept, canonical NaN.
`default_nettype none
module ted_fmul
    import ted_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_mul_req    i_req,
    output logic             o_valid,
    output logic [31:0]      o_value,
    output logic             o_last
);
    // stage 1: unpack and multiply significands
    logic r1_v, r2_v, r3_v;
    logic r1_sgn, r1_last, r1_spec;
    logic [31:0] r1_special;
    logic signed [10:0] r1_exp;
    logic [47:0] r1_prod;
    // stage 2: normalize to leading bit 47
    logic r2_sgn, r2_last, r2_spec;
    logic [31:0] r2_special;
    logic signed [10:0] r2_exp;
    logic [47:0] r2_prod;
    logic [31:0] r3_value;
    logic r3_last;

    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [23:0] ma, mb;
    logic signed [10:0] ea, eb;
    logic [31:0] n_special;
    logic n_spec;
    assign sgn = i_req.a[31] ^ i_req.b[31];
    assign a_nan = &i_req.a[30:23] && |i_req.a[22:0];
    assign b_nan = &i_req.b[30:23] && |i_req.b[22:0];
    assign a_inf = &i_req.a[30:23] && !(|i_req.a[22:0]);
    assign b_inf = &i_req.b[30:23] && !(|i_req.b[22:0]);
    assign a_zero = i_req.a[30:0] == 31'd0;
    assign b_zero = i_req.b[30:0] == 31'd0;
    assign ma = {|i_req.a[30:23], i_req.a[22:0]};
    assign mb = {|i_req.b[30:23], i_req.b[22:0]};
    assign ea = (|i_req.a[30:23]) ? 11'($signed({3'd0, i_req.a[30:23]})) : 11'sd1;
    assign eb = (|i_req.b[30:23]) ? 11'($signed({3'd0, i_req.b[30:23]})) : 11'sd1;
    always_comb begin
        n_spec = 1'b1;
        n_special = {sgn, 31'd0};
        if (i_req.zero_out) n_special = '0;
        else if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            n_special = CANON_NAN;
        else if (a_inf || b_inf) n_special = {sgn, 8'hFF, 23'd0};
        else if (a_zero || b_zero) n_special = {sgn, 31'd0};
        else n_spec = 1'b0;
    end

    // normalize: find leading one (product may have leading zeros from subnormals)
    logic [5:0] lz;
    always_comb begin
        lz = '0;
        for (int i = 0; i < 48; i++) if (r1_prod[i]) lz = 6'(47 - i);
    end

    // stage 3: round
    logic signed [10:0] e_n, sh_r;
    logic [72:0] wide;
    logic [23:0] kept;
    logic g, st, up;
    logic [24:0] rnd;
    logic [31:0] n_val;
    always_comb begin
        // r2_prod has bit 47 set; value = prod * 2^(e-127-46)
        e_n = r2_exp + 11'sd1;
        sh_r = (e_n < 11'sd1) ? 11'sd1 - e_n : 11'sd0;
        if (sh_r > 11'sd26) sh_r = 11'sd26;
        wide = {r2_prod, 25'd0} >> sh_r;
        kept = wide[72:49];
        g = wide[48];
        st = |wide[47:0];
        up = g && (st || kept[0]);
        rnd = {1'b0, kept} + 25'(up);
        if (e_n < 11'sd1) e_n = 11'sd0;
        if (r2_spec) n_val = r2_special;
        else if (rnd[24]) begin
            if (e_n + 11'sd1 >= 11'sd255) n_val = {r2_sgn, 8'hFF, 23'd0};
            else n_val = {r2_sgn, 8'(e_n + 11'sd1), rnd[23:1]};
        end else if (e_n >= 11'sd255) n_val = {r2_sgn, 8'hFF, 23'd0};
        else if (e_n == 11'sd0) n_val = {r2_sgn, 8'(rnd[23]), rnd[22:0]};
        else n_val = {r2_sgn, 8'(e_n), rnd[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (i_en) begin
            r1_sgn <= sgn;
            r1_last <= i_req.last;
            r1_spec <= n_spec;
            r1_special <= n_special;
            r1_exp <= ea + eb - 11'sd127;
            r1_prod <= ma * mb;
            r2_sgn <= r1_sgn;
            r2_last <= r1_last;
            r2_spec <= r1_spec;
            r2_special <= r1_special;
            r2_exp <= r1_exp - 11'($signed({5'd0, lz}));
            r2_prod <= r1_prod << lz;
            r3_value <= n_val;
            r3_last <= r2_last;
        end
    end
    assign o_valid = r3_v;
    assign o_value = r3_value;
    assign o_last = r3_last;
endmodule
`default_nettype wire

>>> rtl/core/table_element_dequantizer.sv
// Top level: multi-format element dequantizer to binary32.
//
//  channel  | dir | tdata (low bit up)                  | tuser/tlast
//  s_axis   | in  | raw_word, col_scale_first, _second  | -
//  m_axis   | out | value_bits                          | tlast = last_of_item
//  cfg      | in  | write: index 0 format, 1 global scale
//
// One request enters per cycle while the output is not stalled; an int4 pair
// drops s_axis_tready while its high nibble follows, so it gives two results.
// An accepted request is registered through the mantissa multiply, normalize
// and round stages before its first result; decode feeds stage one.
// Reset (synchronous, active low) sets format bf16 and global scale 16.0.
// A waiting result with m_axis_tready low stalls the whole pipe in place and
// drops s_axis_tready; nothing is lost or repeated.
`default_nettype none
module table_element_dequantizer
    import ted_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] raw_word, [63:32] col_scale_first, [95:64] col_scale_second
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] value_bits
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    logic [2:0] r_format;
    logic [31:0] r_gscale;
    logic front_valid, pipe_en;
    t_mul_req front_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FORMAT_RESET;
            r_gscale <= GSCALE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FORMAT[0:0]) r_format <= i_cfg_data[2:0];
            else r_gscale <= i_cfg_data;
        end
    end

    // advance the pipe when the output slot is empty or being taken
    assign pipe_en = !m_axis_tvalid || m_axis_tready;

    ted_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_format(r_format), .i_gscale(r_gscale),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_raw(s_axis_tdata[31:0]), .i_cs0(s_axis_tdata[63:32]),
        .i_cs1(s_axis_tdata[95:64]),
        .o_valid(front_valid), .i_ready(pipe_en), .o_req(front_req)
    );

    ted_fmul u_fmul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(pipe_en),
        .i_valid(front_valid), .i_req(front_req),
        .o_valid(m_axis_tvalid), .o_value(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

>>> rtl/core/ted_checker.sv
// Port-level checker for the dequantizer, bound to the top level.
`default_nettype none
`include "table_element_dequantizer_assert.svh"
module ted_checker
    import ted_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    logic out_stall;
    logic out_nan;
    logic [32:0] out_word;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_nan = m_axis_tvalid && (&m_axis_tdata[30:23]) && (|m_axis_tdata[22:0]);
    assign out_word = {m_axis_tlast, m_axis_tdata};

    `TED_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `TED_ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n, out_stall, !s_axis_tready)
    `TED_ASSERT_IMP(a_nan_canon, i_clk, i_rst_n, out_nan, m_axis_tdata == CANON_NAN)
endmodule
bind table_element_dequantizer ted_checker u_ted_checker (.*);
`default_nettype wire
